@@ hw/rtl/sptt_pkg.sv @@
// package for the sorted priority task table
// types, opcodes and status codes shared by the divider, the table and the top level
package sptt_pkg;

    localparam int MAX_TASKS = 16;
    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        FN_INSERT = 3'd0,
        FN_POP    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_READY  = 3'd3,
        FN_PEEK   = 3'd4,
        FN_LCM    = 3'd5
    } func_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_OVERFLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [15:0] prio;
        logic [15:0] period;
    } entry_t;

    // request and response of the shared divider
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quot;
        logic [31:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_READY_DIV,
        S_READY_WAIT,
        S_LCM_NEXT,
        S_GCD_DIV,
        S_GCD_WAIT,
        S_LCM_QDIV,
        S_LCM_QWAIT,
        S_LCM_MUL,
        S_DONE
    } state_t;

endpackage

@@ hw/rtl/sptt_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on sptt_pkg
module sptt_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  sptt_pkg::div_req_t req,
    output sptt_pkg::div_rsp_t rsp
);
    import sptt_pkg::*;

    logic        busy_reg;
    logic [5:0]  cnt_reg;
    logic [31:0] quot_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg, quot_reg[31]} - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
            end else if (busy_reg) begin
                // shift in one dividend bit, subtract when it fits
                if (!trial[32]) begin
                    rem_reg <= trial[31:0];
                    quot_reg <= {quot_reg[30:0], 1'b1};
                end else begin
                    rem_reg <= {rem_reg[30:0], quot_reg[31]};
                    quot_reg <= {quot_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;
endmodule

@@ hw/rtl/sptt_table.sv @@
// sorted entry store: a row of registers that shifts one step per cycle
// depends on sptt_pkg
module sptt_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          shift_up,
    input  logic                          shift_down,
    input  logic [sptt_pkg::IDX_W-1:0]    pos,
    input  logic                          wr_en,
    input  sptt_pkg::entry_t              wr_entry,
    input  logic [sptt_pkg::IDX_W-1:0]    rd_idx,
    output sptt_pkg::entry_t              rd_entry,
    output logic [sptt_pkg::CNT_W-1:0]    count
);
    import sptt_pkg::*;

    entry_t            ent_reg [MAX_TASKS];
    logic [CNT_W-1:0]  count_reg;

    // shift_up opens a hole at pos (insert), shift_down closes it (drop)
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            if (shift_up && (IDX_W'(i) > pos) && i > 0) begin
                ent_reg[i] <= ent_reg[i-1];
            end else if (shift_down && (IDX_W'(i) >= pos) && i < MAX_TASKS - 1) begin
                ent_reg[i] <= ent_reg[i+1];
            end
        end
        if (wr_en) begin
            ent_reg[pos] <= wr_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (wr_en) begin
            count_reg <= count_reg + CNT_W'(1);
        end else if (shift_down) begin
            count_reg <= count_reg - CNT_W'(1);
        end
    end

    assign rd_entry = ent_reg[rd_idx];
    assign count    = count_reg;
endmodule

@@ hw/rtl/sorted_priority_task_table_core.sv @@
// top level of the sorted priority task table
// depends on sptt_pkg, sptt_div and sptt_table
//
// One beat in gives one beat out. A sequencer walks the table one entry per
// cycle, except where the ready check and the lcm wait on a division; they run
// every division through a single restoring divider. Ready is low from the
// accepted beat until the result beat has been taken. Table entries hold no
// reset value.
module sorted_priority_task_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // func[2:0], proc_id[10:3], prio_in[26:11], period_in[42:27], tick[74:43]
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found[0], task_id[8:1], task_prio[24:9], task_period[40:25],
    // lcm_value[72:41], status[75:73]
    output logic [79:0] m_tdata
);
    import sptt_pkg::*;

    state_t state_reg, state_next;

    // latched request
    logic [2:0]  func_reg;
    logic [7:0]  id_reg;
    logic [15:0] prio_reg;
    logic [15:0] period_reg;
    logic [31:0] tick_reg;
    logic [IDX_W-1:0] idx_reg;
    // euclid working pair and running lcm
    logic [31:0] ga_reg, gb_reg, acc_reg;
    logic [31:0] q_reg;
    // result
    logic        found_reg;
    entry_t      res_reg;
    logic [31:0] lcm_reg;
    status_t     status_reg;
    logic        out_valid_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    entry_t   rd_entry;
    logic [CNT_W-1:0] count;
    logic     shift_up, shift_down, wr_en;
    logic [63:0] prod;
    logic     last;

    sptt_div u_div (.aclk, .aresetn, .req(dreq), .rsp(drsp));

    sptt_table u_table (
        .aclk, .aresetn,
        .shift_up, .shift_down,
        .pos(idx_reg), .wr_en,
        .wr_entry({id_reg, prio_reg, period_reg}),
        .rd_idx(idx_reg), .rd_entry, .count
    );

    assign s_tready = (state_reg == S_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, status_reg, lcm_reg, res_reg.period, res_reg.prio,
                       res_reg.id, found_reg};
    assign last     = ({1'b0, idx_reg} + CNT_W'(1)) >= count;
    assign prod     = q_reg * {16'd0, rd_entry.period};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) state_next = S_SCAN;
            S_SCAN: begin
                priority if (func_reg > 3'(FN_LCM)) state_next = S_DONE;
                else if (func_reg == 3'(FN_INSERT)) begin
                    if (count >= CNT_W'(MAX_TASKS)) state_next = S_DONE;
                    else if (CNT_W'(idx_reg) >= count || rd_entry.prio >= prio_reg)
                        state_next = S_DONE;
                end else if (count == '0) state_next = S_DONE;
                else if (func_reg == 3'(FN_POP) || func_reg == 3'(FN_PEEK))
                    state_next = (func_reg == 3'(FN_POP)) ? S_SHIFT : S_DONE;
                else if (func_reg == 3'(FN_REMOVE)) begin
                    if (rd_entry.id == id_reg) state_next = S_SHIFT;
                    else if (last) state_next = S_DONE;
                end else if (func_reg == 3'(FN_READY)) begin
                    if (rd_entry.prio == '0) begin
                        if (last) state_next = S_DONE;
                    end else state_next = S_READY_DIV;
                end else state_next = S_LCM_NEXT;
            end
            S_SHIFT: state_next = S_DONE;
            S_READY_DIV: state_next = S_READY_WAIT;
            S_READY_WAIT: if (drsp.done) begin
                if (drsp.rem == '0 || last) state_next = S_DONE;
                else state_next = S_SCAN;
            end
            S_LCM_NEXT: begin
                if (CNT_W'(idx_reg) >= count) state_next = S_DONE;
                else if (rd_entry.period == '0 || acc_reg == '0)
                    state_next = last ? S_DONE : S_LCM_NEXT;
                else state_next = S_GCD_DIV;
            end
            S_GCD_DIV: state_next = S_GCD_WAIT;
            S_GCD_WAIT: if (drsp.done)
                state_next = (drsp.rem == '0) ? S_LCM_QDIV : S_GCD_DIV;
            S_LCM_QDIV: state_next = S_LCM_QWAIT;
            S_LCM_QWAIT: if (drsp.done) state_next = S_LCM_MUL;
            // the last entry wraps idx to zero, so a full table ends here
            S_LCM_MUL: state_next = (prod[63:32] != '0 || last) ? S_DONE : S_LCM_NEXT;
            S_DONE: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        shift_up   = 1'b0;
        shift_down = 1'b0;
        wr_en      = 1'b0;
        dreq       = '0;
        unique case (state_reg)
            S_SCAN: if (func_reg == 3'(FN_INSERT) && count < CNT_W'(MAX_TASKS) &&
                        (CNT_W'(idx_reg) >= count || rd_entry.prio >= prio_reg)) begin
                shift_up = 1'b1;
                wr_en    = 1'b1;
            end
            S_SHIFT: shift_down = 1'b1;
            S_READY_DIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = tick_reg;
                dreq.divisor  = {16'd0, rd_entry.prio};
            end
            S_GCD_DIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = ga_reg;
                dreq.divisor  = gb_reg;
            end
            S_LCM_QDIV: begin
                dreq.start    = 1'b1;
                dreq.dividend = acc_reg;
                dreq.divisor  = ga_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_DONE) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: if (s_tvalid && s_tready) begin
                func_reg   <= s_tdata[2:0];
                id_reg     <= s_tdata[10:3];
                prio_reg   <= s_tdata[26:11];
                period_reg <= s_tdata[42:27];
                tick_reg   <= s_tdata[74:43];
                idx_reg    <= '0;
                acc_reg    <= 32'd1;
                found_reg  <= 1'b0;
                res_reg    <= '0;
                lcm_reg    <= '0;
                status_reg <= ST_OK;
            end
            S_SCAN: begin
                priority if (func_reg > 3'(FN_LCM)) status_reg <= ST_OK;
                else if (func_reg == 3'(FN_INSERT)) begin
                    if (count >= CNT_W'(MAX_TASKS)) status_reg <= ST_FULL;
                    else if (!(CNT_W'(idx_reg) >= count || rd_entry.prio >= prio_reg))
                        idx_reg <= idx_reg + IDX_W'(1);
                end else if (count == '0) status_reg <= ST_EMPTY;
                else if (func_reg == 3'(FN_POP) || func_reg == 3'(FN_PEEK)) begin
                    found_reg <= 1'b1;
                    res_reg   <= rd_entry;
                end else if (func_reg == 3'(FN_REMOVE)) begin
                    if (rd_entry.id == id_reg) begin
                        found_reg <= 1'b1;
                        res_reg   <= rd_entry;
                    end else if (last) status_reg <= ST_NOTFOUND;
                    else idx_reg <= idx_reg + IDX_W'(1);
                end else if (func_reg == 3'(FN_READY)) begin
                    if (rd_entry.prio == '0) begin
                        if (last) status_reg <= ST_NOTFOUND;
                        else idx_reg <= idx_reg + IDX_W'(1);
                    end
                end
            end
            S_READY_WAIT: if (drsp.done) begin
                if (drsp.rem == '0) begin
                    found_reg <= 1'b1;
                    res_reg   <= rd_entry;
                end else if (last) status_reg <= ST_NOTFOUND;
                else idx_reg <= idx_reg + IDX_W'(1);
            end
            S_LCM_NEXT: begin
                if (CNT_W'(idx_reg) >= count) lcm_reg <= acc_reg;
                else if (rd_entry.period == '0 || acc_reg == '0) begin
                    acc_reg <= '0;
                    idx_reg <= idx_reg + IDX_W'(1);
                    if (last) lcm_reg <= '0;
                end else begin
                    ga_reg <= acc_reg;
                    gb_reg <= {16'd0, rd_entry.period};
                end
            end
            S_GCD_WAIT: if (drsp.done) begin
                ga_reg <= gb_reg;
                gb_reg <= drsp.rem;
                // gcd is the last nonzero divisor
                if (drsp.rem == '0) ga_reg <= gb_reg;
            end
            S_LCM_QWAIT: if (drsp.done) q_reg <= drsp.quot;
            S_LCM_MUL: begin
                if (prod[63:32] != '0) begin
                    lcm_reg    <= 32'hFFFF_FFFF;
                    status_reg <= ST_OVERFLOW;
                end else begin
                    acc_reg <= prod[31:0];
                    if (last) lcm_reg <= prod[31:0];
                    idx_reg <= idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    // an accepted beat always lands in the sequencer
    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == S_SCAN))
        else $error("accepted beat did not start the sequencer");
    // the result appears in the cycle after the done state
    a_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) |=> m_tvalid)
        else $error("result beat missing after done");
    // the table never holds more than its capacity
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        count <= CNT_W'(MAX_TASKS))
        else $error("entry count past capacity");
endmodule

@@ dv/sptt_checker.sv @@
// result checker for the sorted priority task table
// holds its own copy of the table, predicts each result beat and compares; depends on sptt_pkg
`timescale 1ns / 1ps

module sptt_checker
    import sptt_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [79:0] m_tdata,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic        found;
        logic [7:0]  id;
        logic [15:0] prio;
        logic [15:0] period;
        logic [31:0] lcm;
        logic [2:0]  status;
    } task_rsp_t;

    entry_t      shadow[MAX_TASKS];
    int          shadow_count;
    task_rsp_t   rsp_queue[$];

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic task_rsp_t give(int k);
        task_rsp_t r;
        r = '0;
        r.found = 1'b1;
        r.id = shadow[k].id;
        r.prio = shadow[k].prio;
        r.period = shadow[k].period;
        return r;
    endfunction

    task automatic drop(int k);
        for (int i = k; i + 1 < shadow_count; i++) shadow[i] = shadow[i + 1];
        shadow_count--;
    endtask

    task automatic table_step(logic [79:0] d);
        task_rsp_t   r;
        logic [2:0]  fn;
        logic [7:0]  id;
        logic [15:0] pr;
        logic [15:0] pe;
        logic [31:0] tk;
        logic [63:0] acc;
        int          pos;
        fn = d[2:0];
        id = d[10:3];
        pr = d[26:11];
        pe = d[42:27];
        tk = d[74:43];
        r = '0;
        if (fn == FN_INSERT) begin
            if (shadow_count >= MAX_TASKS) begin
                r.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < shadow_count && shadow[pos].prio < pr) pos++;
                for (int i = shadow_count; i > pos; i--) shadow[i] = shadow[i - 1];
                shadow[pos] = '{id: id, prio: pr, period: pe};
                shadow_count++;
                r.status = ST_OK;
            end
        end else if (fn > FN_LCM) begin
            r = '0;
        end else if (shadow_count == 0) begin
            r.status = ST_EMPTY;
        end else begin
            case (fn)
                FN_POP: begin
                    r = give(0);
                    drop(0);
                end
                FN_REMOVE: begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow[i].id == id) begin
                            r = give(i);
                            drop(i);
                            break;
                        end
                    end
                end
                FN_READY: begin
                    r.status = ST_NOTFOUND;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow[i].prio != 0 && tk % shadow[i].prio == 0) begin
                            r = give(i);
                            break;
                        end
                    end
                end
                FN_PEEK: r = give(0);
                default: begin
                    acc = 1;
                    r.status = ST_OK;
                    for (int i = 0; i < shadow_count; i++) begin
                        if (shadow[i].period == 0 || acc == 0) begin
                            acc = 0;
                            continue;
                        end
                        acc = (acc / gcd64(acc, 64'(shadow[i].period))) * shadow[i].period;
                        if (acc > 64'hFFFF_FFFF) begin
                            acc = 64'hFFFF_FFFF;
                            r.status = ST_OVERFLOW;
                            break;
                        end
                    end
                    r.lcm = acc[31:0];
                end
            endcase
        end
        rsp_queue.push_back(r);
    endtask

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        task_rsp_t w;
        if (!aresetn) begin
            shadow_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (rsp_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    w = rsp_queue.pop_front();
                    check_field("found", w.found, m_tdata[0]);
                    check_field("task_id", w.id, m_tdata[8:1]);
                    check_field("task_prio", w.prio, m_tdata[24:9]);
                    check_field("task_period", w.period, m_tdata[40:25]);
                    check_field("lcm_value", w.lcm, m_tdata[72:41]);
                    check_field("status", w.status, m_tdata[75:73]);
                end
            end
            if (s_tvalid && s_tready) table_step(s_tdata);
        end
        pending = rsp_queue.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
        shadow_count = 0;
    end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the sorted priority task table
// drives the core, instantiates sptt_checker beside it; depends on sptt_pkg
`timescale 1ns / 1ps

module testbench;
    import sptt_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    int          fail_count;
    int          pending;
    int          idle_cycles = 0;
    bit          calm = 1'b0;          // no idling in the last part
    bit          hold_sink = 1'b0;     // short receiver hold-off bursts
    bit          long_hold = 1'b0;     // long receiver hold-off

    always #10 aclk = ~aclk;

    sorted_priority_task_table_core u_top (.*);

    sptt_checker u_chk (.*);

    // small id pool so remove by id hits often
    function automatic logic [79:0] make_beat(logic [2:0] fn, logic [7:0] id,
                                              logic [15:0] pr, logic [15:0] pe,
                                              logic [31:0] tk);
        return {5'd0, tk, pe, pr, id, fn};
    endfunction

    // valid drops for the cycle after the handshake, when the core is busy anyway
    task automatic send(logic [79:0] d);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [79:0] rand_beat();
        logic [2:0]  fn;
        logic [15:0] pr;
        logic [15:0] pe;
        logic [31:0] tk;
        int          sel;
        sel = $urandom_range(0, 99);
        if (sel < 38)       fn = FN_INSERT;
        else if (sel < 50)  fn = FN_POP;
        else if (sel < 62)  fn = FN_REMOVE;
        else if (sel < 74)  fn = FN_READY;
        else if (sel < 82)  fn = FN_PEEK;
        else if (sel < 96)  fn = FN_LCM;
        else                fn = 3'($urandom_range(6, 7));
        case ($urandom_range(0, 3))
            0: pr = 16'($urandom);
            1: pr = 16'($urandom_range(0, 12));
            default: pr = 16'($urandom_range(1, 64));
        endcase
        case ($urandom_range(0, 3))
            0: pe = 16'($urandom);
            1: pe = 16'($urandom_range(0, 3));
            default: pe = 16'($urandom_range(1, 40));
        endcase
        tk = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 5000);
        return make_beat(fn, $urandom_range(0, 3) == 0 ? 8'($urandom)
                                                       : 8'($urandom_range(0, 7)),
                         pr, pe, tk);
    endfunction

    // receiver: random bursts of stall unless held or calm
    always @(posedge aclk) begin
        if (hold_sink || long_hold) begin
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    initial begin
        int burst;
        forever begin
            @(posedge aclk);
            if (!calm && !hold_sink && !long_hold && $urandom_range(0, 30) == 0) begin
                burst = $urandom_range(1, 18);
                hold_sink = 1'b1;
                repeat (burst) @(posedge aclk);
                hold_sink = 1'b0;
            end
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 200000) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // directed: empty table cases
        for (int f = FN_POP; f <= 7; f++) send(make_beat(3'(f), 8'd0, 16'd1, 16'd1, 32'd0));
        // extremes and equal priorities
        send(make_beat(FN_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
        send(make_beat(FN_INSERT, 8'h00, 16'h0000, 16'h0001, 32'd0));
        send(make_beat(FN_INSERT, 8'h11, 16'h0005, 16'hFFFE, 32'd0));
        send(make_beat(FN_INSERT, 8'h12, 16'h0005, 16'hFFFD, 32'd0));
        send(make_beat(FN_LCM, 8'd0, 16'd0, 16'd0, 32'd0));    // overflow
        send(make_beat(FN_READY, 8'd0, 16'd0, 16'd0, 32'd10));
        send(make_beat(FN_READY, 8'd0, 16'd0, 16'd0, 32'd7));  // zero prio skipped, no match
        send(make_beat(FN_READY, 8'd0, 16'd0, 16'd0, 32'hFFFF_FFFF));
        send(make_beat(FN_PEEK, 8'd0, 16'd0, 16'd0, 32'd0));
        send(make_beat(FN_REMOVE, 8'h12, 16'd0, 16'd0, 32'd0));
        send(make_beat(FN_REMOVE, 8'h99, 16'd0, 16'd0, 32'd0));
        send(make_beat(FN_INSERT, 8'h20, 16'd3, 16'd0, 32'd0)); // zero period
        send(make_beat(FN_LCM, 8'd0, 16'd0, 16'd0, 32'd0));
        // fill up and overflow the table
        for (int i = 0; i < 14; i++)
            send(make_beat(FN_INSERT, 8'(i), 16'(i + 2), 16'(i + 1), 32'd0));
        send(make_beat(FN_POP, 8'd0, 16'd0, 16'd0, 32'd0));
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                long_hold = 1'b1;
                repeat (3000) @(posedge aclk);
                long_hold = 1'b0;
            end
            for (int i = 0; i < 6; i++) send(rand_beat());
        join
        // sender pause until drained
        wait (pending == 0);
        for (int i = 0; i < 20; i++) send(make_beat(FN_POP, 8'd0, 16'd0, 16'd0, 32'd0));
        for (int n = 0; n < 1400; n++) begin
            if (n == 1250) calm = 1'b1;
            send(rand_beat());
        end
        wait (pending == 0);
        repeat (200) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
